/* sv/pwb_pkg.sv */
// Shared types, widths and codes for the perspective warp block.
package pwb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CHANNELS_DEF   = 4;

  localparam int COORD_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int CHAN_MAX   = 4;
  localparam int PIX_W      = CHAN_MAX * CHAN_W;
  localparam int DIM_W      = 13;
  localparam int CFG_DIM_W  = 11;
  localparam int FRAC_BITS  = 5;
  localparam int TAB_SIZE   = 32;

  localparam int MCOEF_W    = 32;
  localparam int PROD_W     = 43;
  localparam int SUM_W      = 47;
  localparam int MAGN_W     = 43;
  localparam int NUM_SH     = 19;
  localparam int NUM_W      = MAGN_W + NUM_SH;
  localparam int DEN_W      = 46;
  localparam int CMP_W      = 67;
  localparam int Q_BITS     = 21;
  localparam int V_W        = 22;
  localparam int SX_W       = V_W - FRAC_BITS;
  localparam int SC_W       = SX_W + 1;
  localparam int WGT_W      = 16;
  localparam int ACC_W      = 24;
  localparam int ROUND_HALF = 16384;
  localparam int COEF_SHIFT = 15;
  localparam int FIFO_DEPTH = 4;
  localparam int LANE_LAT   = Q_BITS + 1;

  localparam logic [V_W-1:0] COORD_LIMIT = V_W'(1048576);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_OFFS  = 3'd2,
    REG_PERSP = 3'd3,
    REG_WOFF  = 3'd4,
    REG_WIDTH = 3'd5,
    REG_HGT   = 3'd6,
    REG_REPL  = 3'd7
  } reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] ht;
    logic             repl;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic               deg;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   data;
  } side_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic                    deg;
    logic [COORD_W-1:0]      ld_x;
    logic [COORD_W-1:0]      ld_y;
    logic [PIX_W-1:0]        ld_data;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic [3:0][WGT_W-1:0]   wgt;
  } item_t;

  typedef struct packed {
    logic             deg;
    logic [PIX_W-1:0] chans;
  } res_t;

endpackage

/* sv/pwb_div_lane.sv */
// Pipelined restoring divider lane: rounded, saturated source coordinate.
module pwb_div_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [pwb_pkg::NUM_W-1:0]          num_i,
  input  logic [pwb_pkg::DEN_W-1:0]          den_i,
  input  logic                               neg_i,
  input  logic                               sat_i,
  output logic signed [pwb_pkg::V_W-1:0]     v_o
);

  localparam int QB = pwb_pkg::Q_BITS;
  localparam int NW = pwb_pkg::NUM_W;
  localparam int DW = pwb_pkg::DEN_W;
  localparam int CW = pwb_pkg::CMP_W;
  localparam int VW = pwb_pkg::V_W;

  logic [NW-1:0] rem_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [DW-1:0] den_q [QB];
  logic          neg_q [QB];
  logic          sat_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QB-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic          neg_in;
    logic          sat_in;
    logic [CW-1:0] ds;
    logic [CW-1:0] rx;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign sat_in = sat_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
      assign neg_in = neg_q[i-1];
      assign sat_in = sat_q[i-1];
    end

    assign ds = CW'(den_in) << (QB - 1 - i);
    assign rx = CW'(rem_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rx >= ds) begin
          rem_q[i] <= NW'(rx - ds);
          quo_q[i] <= quo_in | (QB'(1) << (QB - 1 - i));
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= quo_in;
        end
        den_q[i] <= den_in;
        neg_q[i] <= neg_in;
        sat_q[i] <= sat_in;
      end
    end
  end

  logic [NW:0]   two_r;
  logic [NW:0]   den_x;
  logic          inc;
  logic [VW-1:0] qr;
  logic [VW-1:0] mag;
  logic signed [VW-1:0] v_d, v_q;

  always_comb begin
    two_r = {rem_q[QB-1], 1'b0};
    den_x = (NW+1)'(den_q[QB-1]);
    inc   = (two_r > den_x) || ((two_r == den_x) && quo_q[QB-1][0]);
    qr    = VW'(quo_q[QB-1]) + VW'(inc);
    mag   = (sat_q[QB-1] || (qr > pwb_pkg::COORD_LIMIT)) ? pwb_pkg::COORD_LIMIT : qr;
    v_d   = neg_q[QB-1] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

/* sv/pwb_chan_lane.sv */
// One channel lane: weighted accumulate of four neighbor beats and final rounding.
module pwb_chan_lane (
  input  logic                         clk_i,
  input  logic                         v_i,
  input  logic                         first_i,
  input  logic                         zero_i,
  input  logic [pwb_pkg::CHAN_W-1:0]   pix_i,
  input  logic [pwb_pkg::WGT_W-1:0]    wgt_i,
  output logic [pwb_pkg::CHAN_W-1:0]   val_o
);

  localparam int AW = pwb_pkg::ACC_W;

  logic [AW-1:0] acc_q, acc_d, prod, base, rnd;
  logic [AW-pwb_pkg::COEF_SHIFT-1:0] shr;

  always_comb begin
    prod  = zero_i ? '0 : AW'(pix_i) * AW'(wgt_i);
    base  = first_i ? '0 : acc_q;
    acc_d = base + prod;
    rnd   = acc_q + AW'(pwb_pkg::ROUND_HALF);
    shr   = rnd[AW-1:pwb_pkg::COEF_SHIFT];
    val_o = (shr > (AW-pwb_pkg::COEF_SHIFT)'(255)) ? 8'hFF : pwb_pkg::CHAN_W'(shr);
  end

  always_ff @(posedge clk_i) begin
    if (v_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

/* sv/pwb_sampler.sv */
// Image store, neighbor read sequencer, channel lanes, merge and result queue.
module pwb_sampler #(
  parameter int MAX_WIDTH  = pwb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pwb_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = pwb_pkg::CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pwb_pkg::cfg_t             cfg_i,
  input  logic                      item_v_i,
  input  pwb_pkg::item_t            item_i,
  output logic                      take_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output pwb_pkg::res_t             m_res_o
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = CHANNELS * pwb_pkg::CHAN_W;
  localparam int FD    = pwb_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(FD);
  localparam int CNW   = PW + 1;
  localparam int SCW   = pwb_pkg::SC_W;
  localparam int DW    = pwb_pkg::DIM_W;

  logic [MW-1:0] mem [DEPTH];

  logic           busy_q, busy_d;
  logic [1:0]     step_q, step_d;
  pwb_pkg::item_t cur_q;
  logic [CNW-1:0] credit_q, credit_d;

  logic is_map, take_map, wr_en, pop;
  logic [DW-1:0] ldx_ext, ldy_ext;
  logic [AW-1:0] waddr, raddr;

  always_comb begin
    is_map  = (item_i.cmd == pwb_pkg::CMD_MAP);
    if (is_map) begin
      take_o = item_v_i && (!busy_q || (step_q == 2'd3)) && (credit_q < CNW'(FD));
    end else begin
      take_o = item_v_i && !busy_q;
    end
    take_map = take_o && is_map;
    ldx_ext  = DW'(item_i.ld_x);
    ldy_ext  = DW'(item_i.ld_y);
    wr_en    = take_o && !is_map && (ldx_ext < DW'(MAX_WIDTH)) && (ldy_ext < DW'(MAX_HEIGHT));
    waddr    = AW'(ldy_ext[YW-1:0]) * AW'(MAX_WIDTH) + AW'(ldx_ext[XW-1:0]);
  end

  // neighbor address for the current issue step
  logic signed [SCW-1:0] cx, cy, wd_s, ht_s;
  logic oob, zero;

  always_comb begin
    wd_s = $signed(SCW'(cfg_i.wd));
    ht_s = $signed(SCW'(cfg_i.ht));
    cx   = SCW'(cur_q.sx) + SCW'(step_q[0]);
    cy   = SCW'(cur_q.sy) + SCW'(step_q[1]);
    oob  = cx[SCW-1] || (cx >= wd_s) || cy[SCW-1] || (cy >= ht_s);
    if (cfg_i.repl) begin
      if (cx[SCW-1]) begin
        cx = '0;
      end else if (cx >= wd_s) begin
        cx = wd_s - SCW'(1);
      end
      if (cy[SCW-1]) begin
        cy = '0;
      end else if (cy >= ht_s) begin
        cy = ht_s - SCW'(1);
      end
    end
    zero  = cur_q.deg || (!cfg_i.repl && oob);
    raddr = AW'(cy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cx[XW-1:0]);
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (take_map) begin
      busy_d = 1'b1;
      step_d = 2'd0;
    end else if (busy_q) begin
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
      end
      step_d = step_q + 2'd1;
    end
  end

  logic [MW-1:0]             rd_q;
  logic                      rd_v_q;
  logic [1:0]                rd_idx_q;
  logic                      rd_zero_q;
  logic [pwb_pkg::WGT_W-1:0] rd_w_q;
  logic                      rd_deg_q;
  logic                      fin_q;
  logic                      fin_deg_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= item_i.ld_data[MW-1:0];
    end
    if (busy_q) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= 2'd0;
      rd_v_q   <= 1'b0;
      fin_q    <= 1'b0;
      credit_q <= '0;
    end else begin
      busy_q   <= busy_d;
      step_q   <= step_d;
      rd_v_q   <= busy_q;
      fin_q    <= rd_v_q && (rd_idx_q == 2'd3);
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_map) begin
      cur_q <= item_i;
    end
    if (busy_q) begin
      rd_idx_q  <= step_q;
      rd_zero_q <= zero;
      rd_w_q    <= cur_q.wgt[step_q];
      rd_deg_q  <= cur_q.deg;
    end
    if (rd_v_q) begin
      fin_deg_q <= rd_deg_q;
    end
  end

  logic [pwb_pkg::CHAN_MAX-1:0][pwb_pkg::CHAN_W-1:0] lane_val;

  for (genvar c = 0; c < pwb_pkg::CHAN_MAX; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      pwb_chan_lane u_lane (
        .clk_i   (clk_i),
        .v_i     (rd_v_q),
        .first_i (rd_idx_q == 2'd0),
        .zero_i  (rd_zero_q),
        .pix_i   (rd_q[c*pwb_pkg::CHAN_W +: pwb_pkg::CHAN_W]),
        .wgt_i   (rd_w_q),
        .val_o   (lane_val[c])
      );
    end else begin : g_unused
      assign lane_val[c] = '0;
    end
  end

  pwb_pkg::res_t res;

  always_comb begin
    res.deg   = fin_deg_q;
    res.chans = fin_deg_q ? '0 : lane_val;
  end

  pwb_pkg::res_t  fifo_q [FD];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0] cnt_q;

  assign pop        = m_tvalid_o && m_tready_i;
  assign m_tvalid_o = (cnt_q != '0);
  assign m_res_o    = fifo_q[rd_ptr_q];
  assign credit_d   = credit_q + CNW'(take_map) - CNW'(pop);

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fin_q) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + CNW'(fin_q) - CNW'(pop);
    end
  end

  a_credit_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q >= cnt_q) else $error("credit below queue fill");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (cnt_q < CNW'(FD))) else $error("push into full queue");
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !busy_q) else $error("store write during neighbor read");
  a_map_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_map |=> (busy_q && (step_q == 2'd0))) else $error("map item did not start");

endmodule

/* sv/perspective_warp_bilinear_top.sv */
// Top level: config registers, projection pipeline, divider lanes, sampler.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata x,y,chan0..3; tuser command
//  m_axis    out  m_axis_tvalid/tready      tdata chan0..3; tuser degenerate
//  apb       in   psel/penable/pwrite       paddr, pwdata, prdata (64 bit)
//
// A map item holds the single image port while it reads its four neighbors,
// one read per neighbor; a load holds it only for its write. The sampler can
// take the next map item during the last read of the current one. Items pass
// products, sums, 21-stage divider lanes, 4 reads, accumulate and merge. Reset
// clears only control state; the image store is undefined until loaded. If
// output stalls, input tready drops once 4 map items hold the 4-entry queue.
module perspective_warp_bilinear_top #(
  parameter int MAX_WIDTH  = pwb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pwb_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = pwb_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // x[9:0] y[19:10] c0 c1 c2 c3 [51:20], zero
  input  logic [0:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // chan0 chan1 chan2 chan3
  output logic [0:0]  m_axis_tuser,  // degenerate
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PRW = pwb_pkg::PROD_W;
  localparam int SW  = pwb_pkg::SUM_W;
  localparam int LL  = pwb_pkg::LANE_LAT;
  localparam int CW  = pwb_pkg::COORD_W;
  localparam int DW  = pwb_pkg::DIM_W;
  localparam int WW  = pwb_pkg::WGT_W;
  localparam int FB  = pwb_pkg::FRAC_BITS;

  // configuration
  logic [63:0] row0_q, row1_q, offs_q, persp_q;
  logic [31:0] woff_q;
  logic [pwb_pkg::CFG_DIM_W-1:0] width_q, hgt_q;
  logic repl_q;
  logic cfg_wr;
  pwb_pkg::reg_e reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = pwb_pkg::reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= 64'h0001_0000_0000_0000;
      row1_q  <= 64'h0000_0000_0001_0000;
      offs_q  <= '0;
      persp_q <= '0;
      woff_q  <= 32'h0001_0000;
      width_q <= 11'd1024;
      hgt_q   <= 11'd1024;
      repl_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        pwb_pkg::REG_ROW0:  row0_q  <= pwdata;
        pwb_pkg::REG_ROW1:  row1_q  <= pwdata;
        pwb_pkg::REG_OFFS:  offs_q  <= pwdata;
        pwb_pkg::REG_PERSP: persp_q <= pwdata;
        pwb_pkg::REG_WOFF:  woff_q  <= pwdata[31:0];
        pwb_pkg::REG_WIDTH: width_q <= pwdata[10:0];
        pwb_pkg::REG_HGT:   hgt_q   <= pwdata[10:0];
        pwb_pkg::REG_REPL:  repl_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pwb_pkg::REG_ROW0:  prdata = row0_q;
      pwb_pkg::REG_ROW1:  prdata = row1_q;
      pwb_pkg::REG_OFFS:  prdata = offs_q;
      pwb_pkg::REG_PERSP: prdata = persp_q;
      pwb_pkg::REG_WOFF:  prdata = 64'(woff_q);
      pwb_pkg::REG_WIDTH: prdata = 64'(width_q);
      pwb_pkg::REG_HGT:   prdata = 64'(hgt_q);
      pwb_pkg::REG_REPL:  prdata = 64'(repl_q);
      default:            prdata = '0;
    endcase
  end

  pwb_pkg::cfg_t cfg;

  always_comb begin
    cfg.repl = repl_q;
    if (width_q == '0) begin
      cfg.wd = DW'(1);
    end else if (DW'(width_q) > DW'(MAX_WIDTH)) begin
      cfg.wd = DW'(MAX_WIDTH);
    end else begin
      cfg.wd = DW'(width_q);
    end
    if (hgt_q == '0) begin
      cfg.ht = DW'(1);
    end else if (DW'(hgt_q) > DW'(MAX_HEIGHT)) begin
      cfg.ht = DW'(MAX_HEIGHT);
    end else begin
      cfg.ht = DW'(hgt_q);
    end
  end

  // projection pipeline, all stages move together on adv
  logic adv, take, tail_v_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [LL-1:0] vl_q;
  pwb_pkg::side_t sb1_q, sb2_q, sb3_q, sb4_q;
  pwb_pkg::side_t sbl_q [LL];
  pwb_pkg::side_t sb1_d, sb4_d;

  assign adv           = !tail_v_q || take;
  assign s_axis_tready = adv;

  always_comb begin
    sb1_d.cmd  = pwb_pkg::cmd_e'(s_axis_tuser[0]);
    sb1_d.deg  = 1'b0;
    sb1_d.x    = s_axis_tdata[9:0];
    sb1_d.y    = s_axis_tdata[19:10];
    sb1_d.data = s_axis_tdata[51:20];
  end

  logic signed [CW:0] xs, ys;
  logic signed [31:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
  logic signed [PRW-1:0] p0_d, p1_d, p3_d, p4_d, p6_d, p7_d;
  logic signed [PRW-1:0] p0_q, p1_q, p3_q, p4_q, p6_q, p7_q;
  logic signed [SW-1:0] px_q, py_q, pw_q;

  always_comb begin
    xs = $signed({1'b0, sb1_q.x});
    ys = $signed({1'b0, sb1_q.y});
    m0 = $signed(row0_q[63:32]);
    m1 = $signed(row0_q[31:0]);
    m3 = $signed(row1_q[63:32]);
    m4 = $signed(row1_q[31:0]);
    m2 = $signed(offs_q[63:32]);
    m5 = $signed(offs_q[31:0]);
    m6 = $signed(persp_q[63:32]);
    m7 = $signed(persp_q[31:0]);
    m8 = $signed(woff_q);
    p0_d = PRW'(m0) * PRW'(xs);
    p1_d = PRW'(m1) * PRW'(ys);
    p3_d = PRW'(m3) * PRW'(xs);
    p4_d = PRW'(m4) * PRW'(ys);
    p6_d = PRW'(m6) * PRW'(xs);
    p7_d = PRW'(m7) * PRW'(ys);
  end

  logic [SW-1:0] pxa, pya, pwa;
  logic [pwb_pkg::NUM_W-1:0] numx_d, numy_d, numx_q, numy_q;
  logic [pwb_pkg::DEN_W-1:0] den_d, den_q;
  logic negx_q, negy_q, satx_q, saty_q;

  always_comb begin
    pxa    = px_q[SW-1] ? SW'(-px_q) : SW'(px_q);
    pya    = py_q[SW-1] ? SW'(-py_q) : SW'(py_q);
    pwa    = pw_q[SW-1] ? SW'(-pw_q) : SW'(pw_q);
    numx_d = {pxa[pwb_pkg::MAGN_W-1:0], pwb_pkg::NUM_SH'(0)};
    numy_d = {pya[pwb_pkg::MAGN_W-1:0], pwb_pkg::NUM_SH'(0)};
    den_d  = pwa[pwb_pkg::DEN_W-1:0];
    sb4_d     = sb3_q;
    sb4_d.deg = (pw_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb1_q <= sb1_d;
      sb2_q <= sb1_q;
      p0_q <= p0_d;
      p1_q <= p1_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      p6_q <= p6_d;
      p7_q <= p7_d;
      sb3_q <= sb2_q;
      px_q  <= SW'(p0_q) + SW'(p1_q) + SW'(m2);
      py_q  <= SW'(p3_q) + SW'(p4_q) + SW'(m5);
      pw_q  <= SW'(p6_q) + SW'(p7_q) + (SW'(m8) <<< 14);
      sb4_q  <= sb4_d;
      numx_q <= numx_d;
      numy_q <= numy_d;
      den_q  <= den_d;
      negx_q <= px_q[SW-1] ^ pw_q[SW-1];
      negy_q <= py_q[SW-1] ^ pw_q[SW-1];
      satx_q <= pwb_pkg::CMP_W'(numx_d) >= (pwb_pkg::CMP_W'(den_d) << pwb_pkg::Q_BITS);
      saty_q <= pwb_pkg::CMP_W'(numy_d) >= (pwb_pkg::CMP_W'(den_d) << pwb_pkg::Q_BITS);
      sbl_q[0] <= sb4_q;
      for (int i = 1; i < LL; i++) begin
        sbl_q[i] <= sbl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      vl_q     <= '0;
      tail_v_q <= 1'b0;
    end else if (adv) begin
      v1_q     <= s_axis_tvalid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      vl_q     <= {vl_q[LL-2:0], v4_q};
      tail_v_q <= vl_q[LL-1];
    end
  end

  logic signed [pwb_pkg::V_W-1:0] vx, vy;

  pwb_div_lane u_lane_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx_q),
    .den_i (den_q),
    .neg_i (negx_q),
    .sat_i (satx_q),
    .v_o   (vx)
  );

  pwb_div_lane u_lane_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy_q),
    .den_i (den_q),
    .neg_i (negy_q),
    .sat_i (saty_q),
    .v_o   (vy)
  );

  // bilinear weights and integer source position
  pwb_pkg::item_t tail_d, tail_q;
  logic [FB:0] ax, ay, kx, ky;

  always_comb begin
    kx = {1'b0, vx[FB-1:0]};
    ky = {1'b0, vy[FB-1:0]};
    ax = (FB+1)'(pwb_pkg::TAB_SIZE) - kx;
    ay = (FB+1)'(pwb_pkg::TAB_SIZE) - ky;
    tail_d.cmd     = sbl_q[LL-1].cmd;
    tail_d.deg     = sbl_q[LL-1].deg;
    tail_d.ld_x    = sbl_q[LL-1].x;
    tail_d.ld_y    = sbl_q[LL-1].y;
    tail_d.ld_data = sbl_q[LL-1].data;
    tail_d.sx      = vx[pwb_pkg::V_W-1:FB];
    tail_d.sy      = vy[pwb_pkg::V_W-1:FB];
    tail_d.wgt[0]  = (WW'(ax) * WW'(ay)) << FB;
    tail_d.wgt[1]  = (WW'(kx) * WW'(ay)) << FB;
    tail_d.wgt[2]  = (WW'(ax) * WW'(ky)) << FB;
    tail_d.wgt[3]  = (WW'(kx) * WW'(ky)) << FB;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tail_q <= tail_d;
    end
  end

  pwb_pkg::res_t res;

  pwb_sampler #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_sampler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_v_i   (tail_v_q),
    .item_i     (tail_q),
    .take_o     (take),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_res_o    (res)
  );

  assign m_axis_tdata    = res.chans;
  assign m_axis_tuser[0] = res.deg;

endmodule
